>>> rtl/core/lbq_pkg.sv
// ----------------------------------------------------------------------------
// lbq_pkg
// Shared types and constants for the linked block queue.
// ----------------------------------------------------------------------------
package lbq_pkg;

    localparam int DEF_NUM_BLOCKS = 4096;
    localparam int FIELD_W        = 12;
    localparam int OP_W           = 2;

    typedef enum logic [OP_W-1:0] {
        OP_POLL   = 2'd0,
        OP_APPEND = 2'd1,
        OP_RANGE  = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_POLL,
        ST_LINK_TAIL,
        ST_LINK_LAST,
        ST_NOP,
        ST_CLR_LIST
    } state_t;

    typedef enum logic [2:0] {
        CMT_NONE,
        CMT_KEEP,
        CMT_POLL,
        CMT_APPEND,
        CMT_CLEAR
    } commit_t;

    typedef struct packed {
        logic    sweep;
        logic    latch;
        logic    wr_tail;
        logic    wr_last;
        commit_t commit;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic has_blocks;
        logic in_range;
        logic out_free;
    } status_t;

endpackage

>>> rtl/core/lbq_ram.sv
// ----------------------------------------------------------------------------
// lbq_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module lbq_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/lbq_ctrl.sv
// ----------------------------------------------------------------------------
// lbq_ctrl
// Sequencer for the queue operations and the link memory sweep after reset.
// ----------------------------------------------------------------------------
module lbq_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [lbq_pkg::OP_W-1:0] opcode,
    output logic                    in_stall,
    input  lbq_pkg::status_t        sts,
    output lbq_pkg::cmd_t           cmd
);

    lbq_pkg::state_t  state_reg;
    lbq_pkg::state_t  state_next;
    lbq_pkg::opcode_t op;

    assign op = lbq_pkg::opcode_t'(opcode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbq_pkg::ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbq_pkg::ST_SWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next = lbq_pkg::ST_IDLE;
                end
            end
            lbq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        lbq_pkg::OP_POLL:
                        begin
                            state_next = sts.has_blocks ? lbq_pkg::ST_POLL
                                                        : lbq_pkg::ST_NOP;
                        end
                        lbq_pkg::OP_APPEND, lbq_pkg::OP_RANGE:
                        begin
                            if (!sts.in_range)
                            begin
                                state_next = lbq_pkg::ST_NOP;
                            end
                            else if (sts.has_blocks)
                            begin
                                state_next = lbq_pkg::ST_LINK_TAIL;
                            end
                            else
                            begin
                                state_next = lbq_pkg::ST_LINK_LAST;
                            end
                        end
                        lbq_pkg::OP_CLEAR:
                        begin
                            state_next = lbq_pkg::ST_CLR_LIST;
                        end
                        default:
                        begin
                            state_next = lbq_pkg::ST_NOP;
                        end
                    endcase
                end
            end
            lbq_pkg::ST_LINK_TAIL:
            begin
                state_next = lbq_pkg::ST_LINK_LAST;
            end
            lbq_pkg::ST_POLL, lbq_pkg::ST_LINK_LAST, lbq_pkg::ST_NOP,
            lbq_pkg::ST_CLR_LIST:
            begin
                if (sts.out_free)
                begin
                    state_next = lbq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.commit  = lbq_pkg::CMT_NONE;
        in_stall    = 1'b1;
        unique case (state_reg)
            lbq_pkg::ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
            end
            lbq_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
            end
            lbq_pkg::ST_POLL:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = lbq_pkg::CMT_POLL;
                end
            end
            lbq_pkg::ST_LINK_TAIL:
            begin
                cmd.wr_tail = 1'b1;
            end
            lbq_pkg::ST_LINK_LAST:
            begin
                // rewriting the end mark while the output is held is harmless
                cmd.wr_last = 1'b1;
                if (sts.out_free)
                begin
                    cmd.commit = lbq_pkg::CMT_APPEND;
                end
            end
            lbq_pkg::ST_NOP:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = lbq_pkg::CMT_KEEP;
                end
            end
            lbq_pkg::ST_CLR_LIST:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = lbq_pkg::CMT_CLEAR;
                end
            end
            default:
            begin
                cmd.commit = lbq_pkg::CMT_NONE;
            end
        endcase
    end

endmodule

>>> rtl/core/lbq_datapath.sv
// ----------------------------------------------------------------------------
// lbq_datapath
// Head, tail and link memory of the block list, plus the output register.
// ----------------------------------------------------------------------------
module lbq_datapath #(
    parameter int NUM_BLOCKS = lbq_pkg::DEF_NUM_BLOCKS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lbq_pkg::OP_W-1:0]    opcode,
    input  logic [lbq_pkg::FIELD_W-1:0] first_index,
    input  logic [lbq_pkg::FIELD_W-1:0] last_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lbq_pkg::FIELD_W-1:0] polled_index,
    output logic                        polled_valid,
    output logic                        list_empty,
    input  lbq_pkg::cmd_t               cmd,
    output lbq_pkg::status_t            sts
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);

    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic              has_reg;
    logic [IDX_W-1:0]  sweep_reg;
    logic [IDX_W-1:0]  first_reg;
    logic [IDX_W-1:0]  last_reg;
    logic              out_valid_reg;
    logic [lbq_pkg::FIELD_W-1:0] out_index_reg;
    logic              out_pvalid_reg;
    logic              out_empty_reg;

    logic              first_ok;
    logic              last_ok;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic [LINK_W-1:0] link;
    logic [IDX_W-1:0]  poll_next;
    logic              poll_end;
    logic              out_free;

    assign first_ok = first_index < NUM_BLOCKS;
    assign last_ok  = last_index < NUM_BLOCKS;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.sweep_last = sweep_reg == LAST_IDX;
        sts.has_blocks = has_reg;
        sts.out_free   = out_free;
        sts.in_range   = (lbq_pkg::opcode_t'(opcode) == lbq_pkg::OP_RANGE)
                         ? (first_ok && last_ok) : first_ok;
    end

    // link memory write port: sweep, tail relink or end mark
    always_comb
    begin
        wr_en   = cmd.sweep || cmd.wr_tail || cmd.wr_last;
        wr_addr = sweep_reg;
        wr_data = '0;
        if (cmd.wr_tail)
        begin
            wr_addr = tail_reg;
            wr_data = LINK_W'(first_reg);
        end
        else if (cmd.wr_last)
        begin
            wr_addr = last_reg;
            wr_data = LINK_END;
        end
    end

    lbq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (head_reg),
        .rd_data (link)
    );

    // successor of the head; a zero link means the following index
    always_comb
    begin
        if (link == '0)
        begin
            poll_next = head_reg + 1'b1;
            poll_end  = head_reg == LAST_IDX;
        end
        else
        begin
            poll_next = link[IDX_W-1:0];
            poll_end  = link >= LINK_END;
        end
        if (head_reg == tail_reg)
        begin
            poll_end = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_reg <= sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            first_reg <= IDX_W'(first_index);
            if (lbq_pkg::opcode_t'(opcode) == lbq_pkg::OP_RANGE)
            begin
                last_reg <= IDX_W'(last_index);
            end
            else
            begin
                last_reg <= IDX_W'(first_index);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            has_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.commit)
                lbq_pkg::CMT_POLL:
                begin
                    if (poll_end)
                    begin
                        head_reg <= '0;
                        has_reg  <= 1'b0;
                    end
                    else
                    begin
                        head_reg <= poll_next;
                    end
                end
                lbq_pkg::CMT_APPEND:
                begin
                    if (!has_reg)
                    begin
                        head_reg <= first_reg;
                    end
                    tail_reg <= last_reg;
                    has_reg  <= 1'b1;
                end
                lbq_pkg::CMT_CLEAR:
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                    has_reg  <= 1'b0;
                end
                default:
                begin
                    has_reg <= has_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit != lbq_pkg::CMT_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.commit)
            lbq_pkg::CMT_POLL:
            begin
                out_index_reg  <= lbq_pkg::FIELD_W'(head_reg);
                out_pvalid_reg <= 1'b1;
                out_empty_reg  <= poll_end;
            end
            lbq_pkg::CMT_APPEND:
            begin
                out_index_reg  <= '0;
                out_pvalid_reg <= 1'b0;
                out_empty_reg  <= 1'b0;
            end
            lbq_pkg::CMT_CLEAR:
            begin
                out_index_reg  <= '0;
                out_pvalid_reg <= 1'b0;
                out_empty_reg  <= 1'b1;
            end
            lbq_pkg::CMT_KEEP:
            begin
                out_index_reg  <= '0;
                out_pvalid_reg <= 1'b0;
                out_empty_reg  <= !has_reg;
            end
            default:
            begin
                out_index_reg <= out_index_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign polled_index = out_index_reg;
    assign polled_valid = out_pvalid_reg;
    assign list_empty   = out_empty_reg;

endmodule

>>> rtl/core/linked_block_queue.sv
// ----------------------------------------------------------------------------
// linked_block_queue
// FIFO list of heap block indices, ordered through a per-block link memory.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | opcode, first_index, last_index
//  out     | out_valid / out_stall| polled_index, polled_valid, list_empty
//
//  poll, clear and ignored appends go through the poll, clear or nop state;
//  the head's link is read from the registered-read link RAM before the new
//  head is known. an append to a non-empty list goes through link-tail, then
//  link-last: tail link and end mark share the single RAM write port in turn.
//  after reset the link RAM is swept to zero with in_stall high.
//  a held result stalls the block only when the next one is ready to leave.
// ----------------------------------------------------------------------------
module linked_block_queue #(
    parameter int NUM_BLOCKS = lbq_pkg::DEF_NUM_BLOCKS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lbq_pkg::OP_W-1:0]    opcode,
    input  logic [lbq_pkg::FIELD_W-1:0] first_index,
    input  logic [lbq_pkg::FIELD_W-1:0] last_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lbq_pkg::FIELD_W-1:0] polled_index,
    output logic                        polled_valid,
    output logic                        list_empty
);

    lbq_pkg::cmd_t    cmd;
    lbq_pkg::status_t sts;

    lbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lbq_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (opcode),
        .first_index  (first_index),
        .last_index   (last_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .polled_index (polled_index),
        .polled_valid (polled_valid),
        .list_empty   (list_empty),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

>>> tb/linked_block_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linked_block_queue_checker
// Watches both channels of the linked block queue. Every accepted command
// beat is run through a local model of the block list and its link memory,
// and the outcome is queued. Each accepted result beat is compared field by
// field with the oldest queued outcome. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module linked_block_queue_checker
    import lbq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [OP_W-1:0]    opcode,
    input  logic [FIELD_W-1:0] first_index,
    input  logic [FIELD_W-1:0] last_index,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [FIELD_W-1:0] polled_index,
    input  logic               polled_valid,
    input  logic               list_empty,
    output int                 fail_count,
    output int                 pending_count
);

    localparam int NB     = DEF_NUM_BLOCKS;
    localparam int LINK_W = $clog2(NB + 1);
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NB);

    typedef struct packed {
        logic [FIELD_W-1:0] polled_index;
        logic               polled_valid;
        logic               list_empty;
    } list_result_t;

    logic [FIELD_W-1:0] m_head;
    logic [FIELD_W-1:0] m_tail;
    logic               m_filled;
    logic [LINK_W-1:0]  m_link [NB];

    list_result_t due_results [$];

    function automatic void link_chain(input logic [FIELD_W-1:0] first,
                                       input logic [FIELD_W-1:0] last);
        if (!m_filled)
            m_head = first;
        else
            m_link[m_tail] = LINK_W'(first);
        m_tail         = last;
        m_link[last]   = LINK_END;
        m_filled       = 1'b1;
    endfunction

    function automatic list_result_t step_block_list(opcode_t op, logic [FIELD_W-1:0] first,
                                                     logic [FIELD_W-1:0] last);
        list_result_t res;
        logic [FIELD_W-1:0] cur;
        logic [LINK_W-1:0]  lk;
        int                 nxt;
        bit                 at_end;
        res = '0;
        case (op)
            OP_POLL:
            begin
                if (m_filled)
                begin
                    cur = m_head;
                    lk  = m_link[cur];
                    res.polled_index = cur;
                    res.polled_valid = 1'b1;
                    // zero link means the block right after this one
                    if (lk == '0)
                    begin
                        nxt    = int'(cur) + 1;
                        at_end = (nxt >= NB);
                    end
                    else
                    begin
                        nxt    = int'(lk);
                        at_end = (int'(lk) >= NB);
                    end
                    if (cur == m_tail)
                        at_end = 1'b1;
                    if (at_end)
                    begin
                        m_filled = 1'b0;
                        m_head   = '0;
                    end
                    else
                        m_head = FIELD_W'(nxt);
                end
            end
            OP_APPEND:
            begin
                if (int'(first) < NB)
                    link_chain(first, first);
            end
            OP_RANGE:
            begin
                if (int'(first) < NB && int'(last) < NB)
                    link_chain(first, last);
            end
            default:
            begin
                // clear leaves link memory as it is
                m_head   = '0;
                m_tail   = '0;
                m_filled = 1'b0;
            end
        endcase
        res.list_empty = !m_filled;
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        list_result_t exp_r;
        int           errs;
        if (!rst_n)
        begin
            m_head   = '0;
            m_tail   = '0;
            m_filled = 1'b0;
            for (int i = 0; i < NB; i++)
                m_link[i] = '0;
            due_results.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && !in_stall)
                due_results.push_back(step_block_list(opcode_t'(opcode), first_index,
                                                      last_index));
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error({"result beat with nothing due: polled_index %0d",
                            " polled_valid %0b list_empty %0b"},
                           polled_index, polled_valid, list_empty);
                    errs++;
                end
                else
                begin
                    exp_r = due_results.pop_front();
                    if (polled_index !== exp_r.polled_index)
                    begin
                        $error("polled_index: expected %0d, got %0d",
                               exp_r.polled_index, polled_index);
                        errs++;
                    end
                    if (polled_valid !== exp_r.polled_valid)
                    begin
                        $error("polled_valid: expected %0b, got %0b",
                               exp_r.polled_valid, polled_valid);
                        errs++;
                    end
                    if (list_empty !== exp_r.list_empty)
                    begin
                        $error("list_empty: expected %0b, got %0b",
                               exp_r.list_empty, list_empty);
                        errs++;
                    end
                end
            end
            fail_count    <= fail_count + errs;
            pending_count <= due_results.size();
        end
    end

endmodule

>>> tb/linked_block_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linked_block_queue_tb
// Drives command beats into the linked block queue: a directed run through
// the list corner cases, then weighted random polls, appends, range appends
// and clears over a narrow window of block indices so links get reused.
// Both sides idle at random, with two long output hold-offs and a full drain.
// The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module linked_block_queue_tb;

    import lbq_pkg::*;

    localparam int RANDOM_ITEMS = 1080;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int DRAIN_CYCLES = 32;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [OP_W-1:0]    opcode;
    logic [FIELD_W-1:0] first_index;
    logic [FIELD_W-1:0] last_index;
    logic               out_valid;
    logic               out_stall;
    logic [FIELD_W-1:0] polled_index;
    logic               polled_valid;
    logic               list_empty;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    bit src_quiet   = 1'b0;

    always #5 clk = ~clk;

    linked_block_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .first_index  (first_index),
        .last_index   (last_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .polled_index (polled_index),
        .polled_valid (polled_valid),
        .list_empty   (list_empty)
    );

    linked_block_queue_checker queue_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .first_index   (first_index),
        .last_index    (last_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .polled_index  (polled_index),
        .polled_valid  (polled_valid),
        .list_empty    (list_empty),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** linked_block_queue: FAILED **");
            $finish;
        end
    end

    // mostly a small window so chains cross each other, some near the top end
    function automatic logic [FIELD_W-1:0] pick_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return FIELD_W'($urandom_range(0, 63));
        else if (r < 85)
            return FIELD_W'($urandom_range(4032, 4095));
        else
            return FIELD_W'($urandom_range(0, 4095));
    endfunction

    task automatic send_item(input opcode_t op, input logic [FIELD_W-1:0] first,
                             input logic [FIELD_W-1:0] last);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        first_index <= first;
        last_index  <= last;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // result side: random hold-offs, a quiet stretch and two long holds
    initial
    begin : sink
        int gap;
        int sink_beats;
        sink_beats = 0;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (sink_beats == 150 || sink_beats == 900)
                gap = HOLD_CYCLES;
            else if (sink_beats >= 300 && sink_beats < 450)
                gap = 0;
            else
                gap = $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            sink_beats++;
        end
    end

    initial
    begin : source
        int                 roll;
        opcode_t            op;
        logic [FIELD_W-1:0] f;
        logic [FIELD_W-1:0] l;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        opcode      <= OP_POLL;
        first_index <= '0;
        last_index  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // poll on an empty list
        send_item(OP_POLL,   12'hFFF, 12'hFFF);
        // appending block zero leaves a zero link on the old tail: contiguous
        send_item(OP_APPEND, 12'd5,   12'hFFF);
        send_item(OP_APPEND, 12'd0,   12'hFFF);
        send_item(OP_POLL,   12'd0,   12'd0);
        send_item(OP_POLL,   12'd0,   12'd0);
        send_item(OP_CLEAR,  12'hFFF, 12'hFFF);
        send_item(OP_POLL,   12'd0,   12'd0);
        // implicit successor runs off the top before the tail is reached
        send_item(OP_RANGE,  12'd4093, 12'd100);
        send_item(OP_POLL,   12'd0,   12'd0);
        send_item(OP_POLL,   12'd0,   12'd0);
        send_item(OP_POLL,   12'd0,   12'd0);
        send_item(OP_POLL,   12'd0,   12'd0);
        // explicit link, then the tail ends the list
        send_item(OP_APPEND, 12'd7,   12'd0);
        send_item(OP_APPEND, 12'd9,   12'd0);
        send_item(OP_POLL,   12'd0,   12'd0);
        send_item(OP_POLL,   12'd0,   12'd0);
        // stale end mark inside a range ends the list early
        send_item(OP_APPEND, 12'd20,  12'd0);
        send_item(OP_POLL,   12'd0,   12'd0);
        send_item(OP_RANGE,  12'd20,  12'd40);
        send_item(OP_POLL,   12'd0,   12'd0);
        send_item(OP_RANGE,  12'hAAA, 12'h555);
        send_item(OP_APPEND, 12'h555, 12'hAAA);
        send_item(OP_POLL,   12'h555, 12'hAAA);
        send_item(OP_CLEAR,  12'd0,   12'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            src_quiet = (n >= 300 && n < 400);
            if (n == 600)
                wait_drained();
            roll = $urandom_range(0, 99);
            f    = FIELD_W'($urandom_range(0, 4095));
            l    = FIELD_W'($urandom_range(0, 4095));
            if (roll < 45)
                op = OP_POLL;
            else if (roll < 75)
            begin
                op = OP_APPEND;
                f  = pick_block();
            end
            else if (roll < 93)
            begin
                op = OP_RANGE;
                f  = pick_block();
                l  = pick_block();
            end
            else
                op = OP_CLEAR;
            send_item(op, f, l);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** linked_block_queue: PASSED **");
        else
            $display("** linked_block_queue: FAILED **");
        $finish;
    end

endmodule
